// ----- design/ows_pkg.sv -----
package ows_pkg;

	localparam int ROM_BITS = 64;
	localparam int POS_W = 7;
	localparam int CRC_W = 8;
	localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_PAIR = 2'd2;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic presence;
		logic bit_true;
		logic bit_complement;
	} req_t;

	typedef struct packed {
		logic proceed;
		logic write_valid;
		logic write_bit;
		logic pass_done;
		logic [1:0] status;
		logic [ROM_BITS-1:0] rom_code;
	} rsp_t;

	function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc, input logic b);
		logic [CRC_W-1:0] c;
		c = crc >> 1;
		if (crc[0] ^ b) begin
			c = c ^ CRC_POLY;
		end
		return c;
	endfunction

endpackage

// ----- design/ows_engine.sv -----
module ows_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  ows_pkg::req_t item,
	output ows_pkg::rsp_t res
);
	import ows_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);
	localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);

	logic [ROM_BITS-1:0] rom_bits_q, rom_bits_d;
	logic [POS_W-1:0] last_disc_q, last_disc_d;
	logic [POS_W-1:0] disc_mark_q, disc_mark_d;
	logic [POS_W-1:0] bit_pos_q, bit_pos_d;
	logic last_dev_q, last_dev_d;
	logic in_pass_q, in_pass_d;
	logic [CRC_W-1:0] crc_q, crc_d;

	logic [POS_W-1:0] pos;
	logic [$clog2(ROM_BITS)-1:0] idx;
	logic dir;
	logic mark;
	logic [POS_W-1:0] mark_val;
	logic [CRC_W-1:0] crc_new;

	always_comb begin
		pos = (bit_pos_q == '0 || bit_pos_q > LAST_POS) ? FIRST_POS : bit_pos_q;
		idx = ($clog2(ROM_BITS))'(pos - FIRST_POS);
		mark = 1'b0;
		priority if (item.bit_true || item.bit_complement) begin
			dir = item.bit_true;
		end else if (pos == last_disc_q) begin
			dir = 1'b1;
		end else if (pos > last_disc_q) begin
			dir = 1'b0;
			mark = 1'b1;
		end else begin
			dir = rom_bits_q[idx];
			mark = !dir;
		end
		mark_val = mark ? pos : disc_mark_q;
		crc_new = crc_bit(crc_q, dir);
	end

	always_comb begin
		rom_bits_d = rom_bits_q;
		last_disc_d = last_disc_q;
		disc_mark_d = disc_mark_q;
		bit_pos_d = bit_pos_q;
		last_dev_d = last_dev_q;
		in_pass_d = in_pass_q;
		crc_d = crc_q;
		res = '0;
		unique case (item.operation)
			OP_RESTART: begin
				rom_bits_d = '0;
				last_disc_d = '0;
				disc_mark_d = '0;
				bit_pos_d = FIRST_POS;
				last_dev_d = 1'b0;
				in_pass_d = 1'b0;
				crc_d = '0;
			end
			OP_START: begin
				in_pass_d = 1'b0;
				priority if (last_dev_q) begin
					last_dev_d = 1'b0;
					res.pass_done = 1'b1;
				end else if (!item.presence) begin
					res.pass_done = 1'b1;
				end else begin
					res.proceed = 1'b1;
					in_pass_d = 1'b1;
					bit_pos_d = FIRST_POS;
					disc_mark_d = '0;
					crc_d = '0;
				end
			end
			OP_PAIR: begin
				if (in_pass_q) begin
					if (item.bit_true && item.bit_complement) begin
						last_disc_d = '0;
						in_pass_d = 1'b0;
						res.pass_done = 1'b1;
					end else begin
						rom_bits_d[idx] = dir;
						disc_mark_d = mark_val;
						crc_d = crc_new;
						res.write_valid = 1'b1;
						res.write_bit = dir;
						if (pos == LAST_POS) begin
							last_disc_d = mark_val;
							if (mark_val == '0) begin
								last_dev_d = 1'b1;
							end
							in_pass_d = 1'b0;
							bit_pos_d = FIRST_POS;
							res.pass_done = 1'b1;
							if (crc_new == '0) begin
								res.status = ST_FOUND;
								res.rom_code = rom_bits_d;
							end else begin
								res.status = ST_CRC_ERR;
							end
						end else begin
							bit_pos_d = pos + FIRST_POS;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bits_q <= '0;
			last_disc_q <= '0;
			disc_mark_q <= '0;
			bit_pos_q <= FIRST_POS;
			last_dev_q <= 1'b0;
			in_pass_q <= 1'b0;
			crc_q <= '0;
		end else if (step) begin
			rom_bits_q <= rom_bits_d;
			last_disc_q <= last_disc_d;
			disc_mark_q <= disc_mark_d;
			bit_pos_q <= bit_pos_d;
			last_dev_q <= last_dev_d;
			in_pass_q <= in_pass_d;
			crc_q <= crc_d;
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q >= FIRST_POS && bit_pos_q <= LAST_POS)
		else $error("bit position out of range");

	a_proceed_opens: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.proceed |=> in_pass_q && bit_pos_q == FIRST_POS && crc_q == '0)
		else $error("pass not opened after proceed");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.pass_done |=> !in_pass_q)
		else $error("pass still open after done");

	a_found_crc: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status == ST_FOUND |=> crc_q == '0 && last_disc_q == $past(mark_val))
		else $error("device reported with nonzero CRC");
`endif

endmodule

// ----- design/onewire_rom_search_step.sv -----
// Search ROM decision engine for a 1-Wire master. Each request beat is a
// restart, a start of pass after a bus reset, or one true/complement bit pair,
// and each produces exactly one response beat. A beat is held in the input
// register and its response is captured in the output register, so one beat
// can be taken every cycle while the response side is not stalled; the search
// state is updated once per beat, as its response enters the output register.
module onewire_rom_search_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ows_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ows_pkg::rsp_t rsp
);
	import ows_pkg::*;

	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	rsp_t res;
	logic step;

	assign step = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !step;

	ows_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
		if (step) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

endmodule
